>>> rtl/lir_pkg.sv
// Shared widths, constants and controller/datapath command types for the resampler.
package lir_pkg;

  // Counter width for sample, output and position counters
  localparam int COUNT_BITS = 32;
  localparam int CNT_W      = COUNT_BITS;

  // Field and register widths
  localparam int IR_W      = 18;
  localparam int OR_W      = 16;
  localparam int FC_W      = 32;
  localparam int SMP_W     = 18;
  localparam int OUT_W     = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Rate limits and reset values
  localparam int IR_MIN   = 8000;
  localparam int IR_MAX   = 192000;
  localparam int OR_MIN   = 8000;
  localparam int OR_MAX   = 48000;
  localparam int IR_RESET = 16000;
  localparam int OR_RESET = 16000;
  localparam int FC_RESET = 1;

  // Results per item
  localparam int MAX_RESULTS = 12;
  localparam int RUN_W       = $clog2(MAX_RESULTS + 1);

  // Arithmetic widths
  localparam int PROD_W = CNT_W + OR_W;         // frames * out_rate
  localparam int NUM_W  = SMP_W + OR_W + 1;     // interpolation numerator, signed
  localparam int MAG_W  = SMP_W - 1 + OR_W;     // numerator magnitude bound
  localparam int DVD_W  = (PROD_W > MAG_W) ? PROD_W : MAG_W;
  localparam int DVS_W  = IR_W;
  localparam int LEN_W  = $clog2(DVD_W + 1);

  // Output scaling: clamp to full scale, times 32767, drop 15 fraction bits
  localparam int FULL_SCALE = 32768;
  localparam int SCALE_MUL  = 32767;
  localparam int FRAC_BITS  = 15;
  localparam int QM_W       = SMP_W - 1;
  localparam int SC_W       = QM_W + FRAC_BITS;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_RATE     = 2'd0,
    CFG_OUT_RATE    = 2'd1,
    CFG_FRAME_COUNT = 2'd2
  } cfg_idx_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic tot_start;
    logic tot_apply;
    logic carry_start;
    logic carry_apply;
    logic mul0;
    logic mul1;
    logic add;
    logic int_start;
    logic int_apply;
    logic scale;
    logic pos_start;
    logic pos_apply;
    logic emit;
    logic finish;
  } lir_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic first;
    logic rem_ge;
    logic more;
    logic div_busy;
    logic out_free;
  } lir_sts_t;

endpackage

>>> rtl/lir_if.sv
// Stream channel interfaces for input samples and resampled results.
interface lir_in_if import lir_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

interface lir_out_if import lir_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_sample;
  logic                    last_of_run;
  logic                    end_of_stream;

  modport source (output valid, output out_sample, output last_of_run,
                  output end_of_stream, input ready);
  modport sink   (input valid, input out_sample, input last_of_run,
                  input end_of_stream, output ready);
endinterface

>>> rtl/linear_interp_audio_resampler_top.sv
// Linear interpolation sample rate converter, mono Q2.15 in, int16 out.
// Each result runs the multiply/add, the interpolation divide and the position divide,
// then waits for a free output slot; an item with no result skips them.
// The first item of a stream also runs the output-total divide (PROD_W steps).
// Throughput: one item at a time, set by the shared one-bit-per-cycle divider.
// Reset (rst_n, synchronous low): rates 16000 Hz, frame count 1, all counters cleared.
module linear_interp_audio_resampler_top import lir_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  lir_in_if.sink               in_ch,
  lir_out_if.source            out_ch
);

  lir_cmd_t cmd;
  lir_sts_t sts;

  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lir_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (in_ch.in_sample),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_sample (out_ch.out_sample),
    .out_last   (out_ch.last_of_run),
    .out_eos    (out_ch.end_of_stream),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

>>> rtl/lir_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, variable length.
module lir_div import lir_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [LEN_W-1:0] len,
  input  logic [DVD_W-1:0] dividend,   // left-aligned: top len bits are used
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quot,
  output logic [DVS_W-1:0] rem
);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [LEN_W-1:0] cnt_r;
  logic             busy_r;

  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVS_W:0]   rem_diff;

  // One shift-subtract step
  always_comb begin
    rem_sh   = {rem_r, dvd_r[DVD_W-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    rem_diff = rem_sh - {1'b0, dvs_r};
  end

  // Control: counts down the requested number of steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= len;
    end else if (busy_r) begin
      cnt_r  <= cnt_r - LEN_W'(1);
      busy_r <= (cnt_r != LEN_W'(1));
    end
  end

  // Working registers; quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
      rem_r <= ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

>>> rtl/lir_dp.sv
// Datapath: config registers, stream state, multiplier, divider and output register.
module lir_dp import lir_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_idx,
  input  logic [CFG_W-1:0]        cfg_wdata,
  // input item payload
  input  logic signed [SMP_W-1:0] in_sample,
  // result channel
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_sample,
  output logic                    out_last,
  output logic                    out_eos,
  // controller link
  input  lir_cmd_t                cmd,
  output lir_sts_t                sts
);

  // Configuration registers
  logic [IR_W-1:0] in_rate_r;
  logic [OR_W-1:0] out_rate_r;
  logic [FC_W-1:0] frame_count_r;

  // Stream state
  logic signed [SMP_W-1:0] prev_r;
  logic signed [SMP_W-1:0] cur_r;
  logic [CNT_W-1:0]        seen_r;
  logic [CNT_W-1:0]        done_r;
  logic [CNT_W-1:0]        total_r;
  logic [CNT_W-1:0]        whole_r;
  logic [OR_W-1:0]         frac_r;
  logic                    last_r;
  logic [RUN_W-1:0]        run_r;

  // Arithmetic registers
  logic signed [NUM_W-1:0] mul_r;
  logic signed [NUM_W-1:0] acc_r;
  logic                    neg_r;
  logic [SC_W-1:0]         sc_r;
  logic signed [OUT_W-1:0] pend_r;
  logic                    pend_eos_r;

  // Output register
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_sample_r;
  logic                    out_last_r;
  logic                    out_eos_r;

  // Combinational helpers
  logic [IR_W-1:0]         ir;
  logic [OR_W-1:0]         orate;
  logic [CNT_W-1:0]        frames;
  logic                    last_now;
  logic [PROD_W-1:0]       tot_prod;
  logic [NUM_W-1:0]        acc_abs;
  logic [IR_W-1:0]         pos_sum;
  logic signed [SMP_W-1:0] x0;
  logic signed [SMP_W-1:0] mul_a;
  logic signed [OR_W:0]    mul_b;
  logic [QM_W-1:0]         qm;
  logic [OUT_W-1:0]        mag16;
  logic                    more;

  logic                    div_start;
  logic [LEN_W-1:0]        div_len;
  logic [DVD_W-1:0]        div_dvd;
  logic [DVS_W-1:0]        div_dvs;
  logic                    div_busy;
  logic [DVD_W-1:0]        div_quot;
  logic [DVS_W-1:0]        div_rem;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_rate_r     <= IR_W'(IR_RESET);
      out_rate_r    <= OR_W'(OR_RESET);
      frame_count_r <= FC_W'(FC_RESET);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IN_RATE:     in_rate_r     <= cfg_wdata[IR_W-1:0];
        CFG_OUT_RATE:    out_rate_r    <= cfg_wdata[OR_W-1:0];
        CFG_FRAME_COUNT: frame_count_r <= cfg_wdata[FC_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped rates and frame count
  always_comb begin
    if (in_rate_r < IR_W'(IR_MIN))      ir = IR_W'(IR_MIN);
    else if (in_rate_r > IR_W'(IR_MAX)) ir = IR_W'(IR_MAX);
    else                                ir = in_rate_r;

    if (out_rate_r < OR_W'(OR_MIN))      orate = OR_W'(OR_MIN);
    else if (out_rate_r > OR_W'(OR_MAX)) orate = OR_W'(OR_MAX);
    else                                 orate = out_rate_r;

    if (frame_count_r == '0)                 frames = CNT_W'(1);
    else if ((frame_count_r >> CNT_W) != '0) frames = '1;
    else                                     frames = CNT_W'(frame_count_r);
  end

  // Per-item values
  assign last_now = ({1'b0, seen_r} + (CNT_W+1)'(1)) >= {1'b0, frames};
  assign tot_prod = PROD_W'(frames) * PROD_W'(orate);
  assign acc_abs  = acc_r[NUM_W-1] ? NUM_W'(-acc_r) : NUM_W'(acc_r);
  assign pos_sum  = IR_W'({{(IR_W-OR_W){1'b0}}, frac_r} + ir);
  assign x0       = (whole_r < seen_r) ? prev_r : cur_r;

  // Another output is due for the current item
  assign more = (run_r < RUN_W'(MAX_RESULTS)) && (done_r < total_r) &&
                ((whole_r < seen_r) || (last_r && (whole_r == seen_r)));

  // Divider operand select
  always_comb begin
    div_start = cmd.tot_start | cmd.carry_start | cmd.int_start | cmd.pos_start;
    div_len   = LEN_W'(IR_W);
    div_dvd   = DVD_W'(pos_sum) << (DVD_W - IR_W);
    div_dvs   = DVS_W'(orate);
    priority if (cmd.tot_start) begin
      div_len = LEN_W'(PROD_W);
      div_dvd = DVD_W'(tot_prod) << (DVD_W - PROD_W);
      div_dvs = ir;
    end else if (cmd.carry_start) begin
      div_len = LEN_W'(OR_W);
      div_dvd = DVD_W'(frac_r) << (DVD_W - OR_W);
    end else if (cmd.int_start) begin
      div_len = LEN_W'(MAG_W);
      div_dvd = DVD_W'(acc_abs[MAG_W-1:0]) << (DVD_W - MAG_W);
    end
  end

  lir_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .len      (div_len),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Stream counters and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      seen_r  <= '0;
      done_r  <= '0;
      total_r <= '0;
      whole_r <= '0;
      frac_r  <= '0;
      last_r  <= 1'b0;
      run_r   <= '0;
    end else begin
      if (cmd.load) begin
        last_r <= last_now;
        run_r  <= '0;
      end
      if (cmd.tot_apply) begin
        total_r <= (div_quot[DVD_W-1:CNT_W] != '0) ? '1 : div_quot[CNT_W-1:0];
        done_r  <= '0;
        whole_r <= '0;
        frac_r  <= '0;
      end
      if (cmd.carry_apply || cmd.pos_apply) begin
        whole_r <= whole_r + CNT_W'(div_quot);
        frac_r  <= div_rem[OR_W-1:0];
      end
      if (cmd.pos_apply) begin
        run_r <= run_r + RUN_W'(1);
      end
      if (cmd.scale) begin
        done_r <= done_r + CNT_W'(1);
      end
      // end of item: clear after the last frame, else advance
      if (cmd.finish) begin
        if (last_r) begin
          prev_r  <= '0;
          seen_r  <= '0;
          done_r  <= '0;
          total_r <= '0;
          whole_r <= '0;
          frac_r  <= '0;
        end else begin
          prev_r <= cur_r;
          seen_r <= seen_r + CNT_W'(1);
        end
      end
    end
  end

  // Interpolation: x0*(out_rate-frac) + cur*frac, divided by out_rate, then magnitude clamp and scale
  always_comb begin
    mul_a = cmd.mul0 ? x0 : cur_r;
    mul_b = signed'({1'b0, cmd.mul0 ? (orate - frac_r) : frac_r});
    qm    = (div_quot > DVD_W'(FULL_SCALE)) ? QM_W'(FULL_SCALE) : div_quot[QM_W-1:0];
    mag16 = sc_r[FRAC_BITS +: OUT_W];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) cur_r <= in_sample;
    if (cmd.mul0 || cmd.mul1) mul_r <= NUM_W'(mul_a) * NUM_W'(mul_b);
    if (cmd.mul1) acc_r <= mul_r;
    if (cmd.add) acc_r <= acc_r + mul_r;
    if (cmd.int_start) neg_r <= acc_r[NUM_W-1];
    if (cmd.int_apply) sc_r <= SC_W'(qm) * SC_W'(SCALE_MUL);
    if (cmd.scale) begin
      pend_r     <= neg_r ? -mag16 : mag16;
      pend_eos_r <= (done_r + CNT_W'(1)) == total_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample_r <= pend_r;
      out_last_r   <= ~more;
      out_eos_r    <= pend_eos_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;
  assign out_eos    = out_eos_r;

  // Status to controller
  always_comb begin
    sts.first    = (seen_r == '0);
    sts.rem_ge   = (frac_r >= orate);
    sts.more     = more;
    sts.div_busy = div_busy;
    sts.out_free = ~out_valid_r | out_ready;
  end

endmodule

>>> rtl/lir_ctrl.sv
// Controller: sequences one input item through total, carry, interpolation and emit.
module lir_ctrl import lir_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lir_sts_t sts,
  output lir_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOT_START,
    ST_TOT_WAIT,
    ST_CARRY,
    ST_CARRY_WAIT,
    ST_CHECK,
    ST_MUL0,
    ST_MUL1,
    ST_ADD,
    ST_INT_START,
    ST_INT_WAIT,
    ST_SCALE,
    ST_POS_START,
    ST_POS_WAIT,
    ST_EMIT,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  // Next state and command decode
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = sts.first ? ST_TOT_START : ST_CARRY;
        end
      end
      ST_TOT_START: begin
        cmd.tot_start = 1'b1;
        state_nxt     = ST_TOT_WAIT;
      end
      ST_TOT_WAIT: begin
        if (!sts.div_busy) begin
          cmd.tot_apply = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_CARRY: begin
        if (sts.rem_ge) begin
          cmd.carry_start = 1'b1;
          state_nxt       = ST_CARRY_WAIT;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CARRY_WAIT: begin
        if (!sts.div_busy) begin
          cmd.carry_apply = 1'b1;
          state_nxt       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = sts.more ? ST_MUL0 : ST_FINISH;
      end
      ST_MUL0: begin
        cmd.mul0  = 1'b1;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_INT_START;
      end
      ST_INT_START: begin
        cmd.int_start = 1'b1;
        state_nxt     = ST_INT_WAIT;
      end
      ST_INT_WAIT: begin
        if (!sts.div_busy) begin
          cmd.int_apply = 1'b1;
          state_nxt     = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_POS_START;
      end
      ST_POS_START: begin
        cmd.pos_start = 1'b1;
        state_nxt     = ST_POS_WAIT;
      end
      ST_POS_WAIT: begin
        if (!sts.div_busy) begin
          cmd.pos_apply = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // wait for a free output slot; position is already advanced
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.more ? ST_MUL0 : ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule
